// ===== design/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// Shared constants, types and fixed point helpers for the short-term
// synaptic plasticity block.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int NEURONS = 1024;
  localparam int AW      = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int IDX_W   = 10;
  localparam int LVL_W   = 17;
  localparam int RATE_W  = 16;
  localparam int QDEPTH  = 2;
  localparam int QAW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [LVL_W-1:0] ONE_FX           = 17'h10000;
  localparam logic [RATE_W-1:0] RESET_RATE_DEP  = 16'd33;
  localparam logic [RATE_W-1:0] RESET_RATE_FAC  = 16'd7;
  localparam logic [LVL_W-1:0] RESET_REST_LEVEL = 17'd13107;
  localparam logic [LVL_W-1:0] RESET_JUMP_LEVEL = 17'd13107;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_SPIKE = 1'b1;

  typedef enum logic [1:0] {
    CFG_RATE_DEPRESS = 2'd0,
    CFG_RATE_FACIL   = 2'd1,
    CFG_REST_LEVEL   = 2'd2,
    CFG_JUMP_LEVEL   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SPIKE,
    BK_TICK
  } bk_state_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_depress;
    logic [RATE_W-1:0] rate_facil;
    logic [LVL_W-1:0]  rest_level;
    logic [LVL_W-1:0]  jump_level;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    rate_depress: RESET_RATE_DEP,
    rate_facil:   RESET_RATE_FAC,
    rest_level:   RESET_REST_LEVEL,
    jump_level:   RESET_JUMP_LEVEL
  };

  typedef struct packed {
    logic             is_tick;
    logic [IDX_W-1:0] idx;
  } q_entry_t;

  typedef struct packed {
    logic [LVL_W-1:0] x;
    logic [LVL_W-1:0] u;
  } lvl_t;

  function automatic logic [LVL_W-1:0] sat_one(input logic [LVL_W-1:0] v);
    sat_one = (v > ONE_FX) ? ONE_FX : v;
  endfunction

  // fixed point product, 16 fraction bits dropped
  function automatic logic [LVL_W-1:0] mul_fx(input logic [LVL_W-1:0] a,
                                               input logic [LVL_W-1:0] b);
    logic [2*LVL_W-1:0] prod;
    prod   = a * b;
    mul_fx = prod[LVL_W+15:16];
  endfunction

endpackage

// ===== design/stp_if.sv =====
// ----------------------------------------------------------------------------
// stp_if
// Valid/ready channels for spike and tick requests and for release results.
// ----------------------------------------------------------------------------
interface stp_in_if import stp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IDX_W-1:0] neuron_index;

  modport source(output valid, req_type, neuron_index, input ready);
  modport sink(input valid, req_type, neuron_index, output ready);
endinterface

interface stp_out_if import stp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] release_value;
  logic [IDX_W-1:0] release_neuron;

  modport source(output valid, release_value, release_neuron, input ready);
  modport sink(input valid, release_value, release_neuron, output ready);
endinterface

// ===== design/stp_ram.sv =====
// ----------------------------------------------------------------------------
// stp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module stp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/stp_front.sv =====
// ----------------------------------------------------------------------------
// stp_front
// Accepts requests, drops spikes for absent neurons and queues the rest.
// ----------------------------------------------------------------------------
module stp_front import stp_pkg::*; (
  stp_in_if.sink    in_item,
  input  logic      q_full,
  output logic      q_push,
  output q_entry_t  q_entry
);

  logic in_range;
  logic is_tick;

  assign in_range = (32'(in_item.neuron_index) < 32'(NEURONS));
  assign is_tick  = (in_item.req_type == REQ_TICK);

  assign in_item.ready = !q_full;

  // out-of-range spike is taken and discarded
  assign q_push = in_item.valid && !q_full && (is_tick || in_range);

  assign q_entry.is_tick = is_tick;
  assign q_entry.idx     = in_item.neuron_index;

endmodule

// ===== design/stp_queue.sv =====
// ----------------------------------------------------------------------------
// stp_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module stp_queue import stp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  output logic     head_valid,
  output q_entry_t head,
  input  logic     pop
);

  q_entry_t       slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign full       = (count_r == (QAW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== design/stp_back.sv =====
// ----------------------------------------------------------------------------
// stp_back
// Level store and update engine: clearing pass, spike update, tick sweep.
// ----------------------------------------------------------------------------
module stp_back import stp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_entry_t  q_head,
  output logic      q_pop,
  stp_out_if.source out_result
);

  bk_state_t        state_r, state_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [IDX_W-1:0] spk_idx_r, spk_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0] out_value_r, out_value_nxt;
  logic [IDX_W-1:0] out_neuron_r, out_neuron_nxt;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  lvl_t             ram_wdata, ram_rdata;

  logic [LVL_W-1:0] rest, jump;
  logic [LVL_W-1:0] x_old, u_old;
  logic [LVL_W-1:0] tick_x, tick_u, u_diff, u_step;
  logic             u_below;
  logic [LVL_W-1:0] rel, spk_x, spk_u;
  logic             out_free;

  stp_ram #(
    .WIDTH ($bits(lvl_t)),
    .DEPTH (NEURONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rest  = sat_one(cfg.rest_level);
  assign jump  = sat_one(cfg.jump_level);
  assign x_old = sat_one(ram_rdata.x);
  assign u_old = sat_one(ram_rdata.u);

  // tick relaxation, u steps toward rest without passing it
  assign tick_x  = x_old + mul_fx({1'b0, cfg.rate_depress}, ONE_FX - x_old);
  assign u_below = (rest >= u_old);
  assign u_diff  = u_below ? (rest - u_old) : (u_old - rest);
  assign u_step  = mul_fx({1'b0, cfg.rate_facil}, u_diff);
  assign tick_u  = u_below ? (u_old + u_step) : (u_old - u_step);

  // spike update from the old levels
  assign rel   = mul_fx(x_old, u_old);
  assign spk_x = x_old - rel;
  assign spk_u = sat_one(u_old + mul_fx(jump, ONE_FX - u_old));

  assign out_free = !out_valid_r || out_result.ready;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    spk_idx_nxt    = spk_idx_r;
    out_valid_nxt  = out_valid_r && !out_result.ready;
    out_value_nxt  = out_value_r;
    out_neuron_nxt = out_neuron_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = '{x: sat_one(tick_x), u: sat_one(tick_u)};
    ram_re         = 1'b0;
    ram_raddr      = addr_r + 1'b1;

    unique case (state_r)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '{x: ONE_FX, u: RESET_JUMP_LEVEL};
        addr_nxt  = addr_r + 1'b1;
        if (addr_r == AW'(NEURONS-1)) begin
          addr_nxt  = '0;
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          if (q_head.is_tick) begin
            q_pop     = 1'b1;
            ram_re    = 1'b1;
            ram_raddr = '0;
            addr_nxt  = '0;
            state_nxt = BK_TICK;
          end else if (out_free) begin
            q_pop       = 1'b1;
            ram_re      = 1'b1;
            ram_raddr   = AW'(q_head.idx);
            addr_nxt    = AW'(q_head.idx);
            spk_idx_nxt = q_head.idx;
            state_nxt   = BK_SPIKE;
          end
        end
      end
      BK_SPIKE: begin
        // output register was free when this spike was taken
        ram_we         = 1'b1;
        ram_wdata      = '{x: spk_x, u: spk_u};
        out_valid_nxt  = 1'b1;
        out_value_nxt  = rel;
        out_neuron_nxt = spk_idx_r;
        state_nxt      = BK_IDLE;
      end
      BK_TICK: begin
        // write back entry addr_r while reading the next one
        ram_we = 1'b1;
        if (addr_r == AW'(NEURONS-1)) begin
          addr_nxt  = '0;
          state_nxt = BK_IDLE;
        end else begin
          ram_re   = 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spk_idx_r    <= spk_idx_nxt;
    out_value_r  <= out_value_nxt;
    out_neuron_r <= out_neuron_nxt;
  end

  assign out_result.valid          = out_valid_r;
  assign out_result.release_value  = out_value_r;
  assign out_result.release_neuron = out_neuron_r;

endmodule

// ===== design/short_term_synaptic_plasticity.sv =====
// ----------------------------------------------------------------------------
// short_term_synaptic_plasticity
// Per-neuron resource and use levels with tick relaxation and spike release.
// ----------------------------------------------------------------------------
// in_item carries requests: req_type 0 is a tick that relaxes every neuron,
// req_type 1 is a spike of neuron_index. A spike for a neuron at or above
// NEURONS is taken and dropped. out_result carries one transaction per
// valid spike: release_value = x*u from the levels before the spike, and
// release_neuron. Ticks give no transaction.
// cfg_we/cfg_index/cfg_wdata write the rate, rest and jump registers; write
// them only while no request is in flight.
// A two-entry queue sits between the request side and the update engine.
// A spike passes through the engine as one level RAM read and then one write;
// the engine finishes each spike before it takes the next, and a queued
// spike waits for every spike and tick ahead of it. A tick sweeps the level
// RAM one entry per cycle through the single RAM port pair.
// After reset the engine first clears every entry of the level RAM; the
// queue fills and in_item.ready then stays low until the pass is done.
// While out_result is stalled, a spike at the head of the queue waits; a
// tick at the head still runs.
// ----------------------------------------------------------------------------
module short_term_synaptic_plasticity import stp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  stp_in_if.sink            in_item,
  stp_out_if.source         out_result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [LVL_W-1:0]  cfg_wdata
);

  cfg_t     cfg_r, cfg_nxt;
  logic     q_push, q_full, q_valid, q_pop;
  q_entry_t q_entry, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RATE_DEPRESS: cfg_nxt.rate_depress = cfg_wdata[RATE_W-1:0];
        CFG_RATE_FACIL:   cfg_nxt.rate_facil   = cfg_wdata[RATE_W-1:0];
        CFG_REST_LEVEL:   cfg_nxt.rest_level   = cfg_wdata;
        CFG_JUMP_LEVEL:   cfg_nxt.jump_level   = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  stp_front u_front (
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  stp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  stp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_result (out_result)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks short_term_synaptic_plasticity against a cycle-free predictor of the
// per-neuron resource and use levels. Spike and tick transactions are sent
// through directed cases, register extremes, random traffic with idle bursts,
// a long output stall and a final stretch at full rate. Each release
// transaction is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;
  import stp_pkg::*;

  localparam int TICK_CYCLES   = NEURONS + 1;
  // a tick may run in the engine with two more queued behind it
  localparam int SETTLE_CYCLES = 3 * TICK_CYCLES + 32;
  localparam int FRAC_ONE      = 65536;
  localparam int HOT_COUNT     = 4;

  typedef struct {
    logic [LVL_W-1:0] value;
    logic [IDX_W-1:0] neuron;
  } release_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [LVL_W-1:0] cfg_wdata;

  stp_in_if  spike_ch ();
  stp_out_if release_ch ();

  short_term_synaptic_plasticity uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (spike_ch),
    .out_result (release_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // predicted register and level state
  logic [RATE_W-1:0] rate_dep_m;
  logic [RATE_W-1:0] rate_fac_m;
  logic [LVL_W-1:0]  rest_m;
  logic [LVL_W-1:0]  jump_m;
  logic [LVL_W-1:0]  resource_m [NEURONS];
  logic [LVL_W-1:0]  use_m [NEURONS];

  release_t         release_q [$];
  int               errors = 0;
  bit               idle_on = 1'b1;
  int               hold_request = 0;
  logic [IDX_W-1:0] hot_idx [HOT_COUNT];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_one(input int unsigned v);
    return (v > FRAC_ONE) ? FRAC_ONE : v;
  endfunction

  function automatic int unsigned frac_mul(input int unsigned a, input int unsigned b);
    longint unsigned p;
    p = 64'(a);
    p = (p * b) >> 16;
    return p[31:0];
  endfunction

  // apply one accepted transaction to the predicted state
  function automatic void predict_request(input logic kind, input logic [IDX_W-1:0] idx);
    int unsigned x, u, rest, jump, rel;
    int          i;
    release_t    r;
    if (kind == REQ_TICK) begin
      rest = clamp_one(32'(rest_m));
      for (i = 0; i < NEURONS; i++) begin
        x = clamp_one(32'(resource_m[i]));
        u = clamp_one(32'(use_m[i]));
        x = x + frac_mul(32'(rate_dep_m), FRAC_ONE - x);
        // step truncates toward zero, so u never crosses the rest level
        if (rest >= u) begin
          u = u + frac_mul(32'(rate_fac_m), rest - u);
        end else begin
          u = u - frac_mul(32'(rate_fac_m), u - rest);
        end
        resource_m[i] = LVL_W'(clamp_one(x));
        use_m[i]      = LVL_W'(clamp_one(u));
      end
    end else begin
      x    = clamp_one(32'(resource_m[idx]));
      u    = clamp_one(32'(use_m[idx]));
      jump = clamp_one(32'(jump_m));
      rel  = frac_mul(x, u);
      use_m[idx]      = LVL_W'(clamp_one(u + frac_mul(jump, FRAC_ONE - u)));
      resource_m[idx] = LVL_W'(x - rel);
      r.value  = LVL_W'(rel);
      r.neuron = idx;
      release_q.push_back(r);
    end
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    unique case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return RATE_W'($urandom_range(1, 64));
      default: return RATE_W'($urandom);
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] pick_level();
    unique case ($urandom_range(0, 6))
      0: return '0;
      1: return ONE_FX;
      2: return '1;
      3: return LVL_W'($urandom_range(65537, 131071));
      default: return LVL_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic send_request(input logic kind, input logic [IDX_W-1:0] idx);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      spike_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    spike_ch.valid        <= 1'b1;
    spike_ch.req_type     <= kind;
    spike_ch.neuron_index <= idx;
    do @(posedge clk); while (!spike_ch.ready);
    predict_request(kind, idx);
  endtask

  // stop offering, wait for all releases, optionally let queued ticks finish
  task automatic drain_block(input bit full_settle);
    spike_ch.valid <= 1'b0;
    do @(posedge clk); while (release_q.size() != 0);
    if (full_settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  task automatic load_config(input logic [RATE_W-1:0] rd, input logic [RATE_W-1:0] rf,
                             input logic [LVL_W-1:0] rest, input logic [LVL_W-1:0] jump);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RATE_DEPRESS;
    cfg_wdata <= {1'b0, rd};
    @(posedge clk);
    cfg_index <= CFG_RATE_FACIL;
    cfg_wdata <= {1'b0, rf};
    @(posedge clk);
    cfg_index <= CFG_REST_LEVEL;
    cfg_wdata <= rest;
    @(posedge clk);
    cfg_index <= CFG_JUMP_LEVEL;
    cfg_wdata <= jump;
    @(posedge clk);
    cfg_we     <= 1'b0;
    rate_dep_m = rd;
    rate_fac_m = rf;
    rest_m     = rest;
    jump_m     = jump;
  endtask

  task automatic run_random_phase(input int count);
    int i;
    drain_block(1'b1);
    load_config(pick_rate(), pick_rate(), pick_level(), pick_level());
    for (i = 0; i < HOT_COUNT; i++) begin
      hot_idx[i] = IDX_W'($urandom);
    end
    // mostly repeated spikes on a few neurons so that x depletes and u builds up
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_request(REQ_TICK, IDX_W'($urandom));
      end else if ($urandom_range(0, 3) != 0) begin
        send_request(REQ_SPIKE, hot_idx[$urandom_range(0, HOT_COUNT - 1)]);
      end else begin
        send_request(REQ_SPIKE, IDX_W'($urandom));
      end
    end
  endtask

  task automatic test_reset_levels();
    send_request(REQ_SPIKE, 10'd0);
    send_request(REQ_SPIKE, 10'd1023);
    send_request(REQ_SPIKE, 10'd0);
    send_request(REQ_SPIKE, 10'h2AA);
    send_request(REQ_SPIKE, 10'h155);
    send_request(REQ_TICK, 10'h3FF);
    send_request(REQ_SPIKE, 10'd0);
    send_request(REQ_SPIKE, 10'h2AA);
  endtask

  task automatic test_config_extremes();
    drain_block(1'b1);
    load_config('1, '1, ONE_FX, ONE_FX);
    send_request(REQ_SPIKE, 10'd5);
    send_request(REQ_SPIKE, 10'd5);
    send_request(REQ_TICK, 10'd0);
    send_request(REQ_SPIKE, 10'd5);
    drain_block(1'b1);
    load_config('0, '0, '0, '0);
    send_request(REQ_SPIKE, 10'd7);
    send_request(REQ_TICK, 10'd0);
    send_request(REQ_SPIKE, 10'd7);
    // rest and jump above one are clamped to one
    drain_block(1'b1);
    load_config(16'd1, '1, '1, '1);
    send_request(REQ_SPIKE, 10'd9);
    send_request(REQ_SPIKE, 10'd9);
    send_request(REQ_TICK, 10'd0);
    send_request(REQ_SPIKE, 10'd9);
    // u above the rest level relaxes downward
    drain_block(1'b1);
    load_config(16'd20000, 16'd30000, '0, 17'd40000);
    send_request(REQ_SPIKE, 10'd11);
    send_request(REQ_TICK, 10'd0);
    send_request(REQ_SPIKE, 10'd11);
  endtask

  task automatic test_random_traffic();
    int p;
    for (p = 0; p < 10; p++) begin
      idle_on = (p % 3 != 2);
      run_random_phase(100);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_hold();
    int i;
    drain_block(1'b0);
    hold_request = 200;
    for (i = 0; i < 24; i++) begin
      send_request(REQ_SPIKE, IDX_W'(i % 3 + 100));
    end
    drain_block(1'b0);
    for (i = 0; i < 4; i++) begin
      send_request(REQ_SPIKE, IDX_W'(i + 100));
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    run_random_phase(150);
  endtask

  initial begin : result_ready_driver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    release_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        release_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        release_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        release_ch.ready <= 1'b0;
      end else begin
        release_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    release_t want;
    if (rst_n && release_ch.valid && release_ch.ready) begin
      if (release_q.size() == 0) begin
        errors++;
        $display("%0t: release transaction with none expected, value=%0d neuron=%0d",
                 $time, release_ch.release_value, release_ch.release_neuron);
      end else begin
        want = release_q.pop_front();
        if (release_ch.release_value !== want.value) begin
          errors++;
          $display("%0t: release_value expected %0d actual %0d (neuron %0d)",
                   $time, want.value, release_ch.release_value, want.neuron);
        end
        if (release_ch.release_neuron !== want.neuron) begin
          errors++;
          $display("%0t: release_neuron expected %0d actual %0d",
                   $time, want.neuron, release_ch.release_neuron);
        end
      end
    end
  end

  initial begin : run_limit
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : main_sequence
    int i;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_RATE_DEPRESS;
    cfg_wdata             <= '0;
    spike_ch.valid        <= 1'b0;
    spike_ch.req_type     <= REQ_TICK;
    spike_ch.neuron_index <= '0;
    rate_dep_m = RESET_RATE_DEP;
    rate_fac_m = RESET_RATE_FAC;
    rest_m     = RESET_REST_LEVEL;
    jump_m     = RESET_JUMP_LEVEL;
    for (i = 0; i < NEURONS; i++) begin
      resource_m[i] = ONE_FX;
      use_m[i]      = RESET_JUMP_LEVEL;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_levels();
    test_config_extremes();
    test_random_traffic();
    test_output_hold();
    test_full_rate();

    drain_block(1'b1);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
